// ===== hw/rtl/pol_pkg.sv =====
`timescale 1ns / 1ps

package pol_pkg;

	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 6;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_LOAD,
		ACT_LEFT,
		ACT_RIGHT
	} cell_act_t;

endpackage

// ===== hw/rtl/pol_cell.sv =====
`timescale 1ns / 1ps

module pol_cell (
	input  logic                                clk,
	input  pol_pkg::cell_act_t                  act,
	input  logic signed [pol_pkg::DATA_W-1:0]   din,
	input  logic signed [pol_pkg::DATA_W-1:0]   left_val,
	input  logic signed [pol_pkg::DATA_W-1:0]   right_val,
	output logic signed [pol_pkg::DATA_W-1:0]   val
);
	import pol_pkg::*;

	logic signed [DATA_W-1:0] val_q;

	// entry contents need no reset, count alone says what is valid
	always_ff @(posedge clk) begin
		unique case (act)
			ACT_HOLD:  val_q <= val_q;
			ACT_LOAD:  val_q <= din;
			ACT_LEFT:  val_q <= left_val;
			ACT_RIGHT: val_q <= right_val;
			default:   val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// ===== hw/rtl/positional_ordered_list.sv =====
`timescale 1ns / 1ps
// the result of an item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle while not stalled; the cell row shifts, loads or holds
// every entry in the same cycle, and the read mux over the row sets the cycle time
// the input stalls only while a result waits and the output is stalled
// reset: the entry count and the output valid clear at once, cell contents are not reset
module positional_ordered_list #(
	parameter int CAPACITY = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          opcode,
	input  logic [pol_pkg::POS_W-1:0]           position,
	input  logic signed [pol_pkg::DATA_W-1:0]   data_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic signed [pol_pkg::DATA_W-1:0]   data_out,
	output logic [pol_pkg::COUNT_W-1:0]         count,
	output logic                                empty_res
);
	import pol_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int IW   = $clog2(CAPACITY);

	logic [CW-1:0]            cnt_q;
	logic                     out_valid_q;
	logic                     ok_q;
	logic signed [DATA_W-1:0] dout_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     empty_q;

	logic [CMPW-1:0] pos_ext, cnt_ext, idx, cnt_nxt;
	logic            acc, pos_nz, in_list, ins_ok, rd_ok, wr_ok, rem_ok, clr;
	logic            res_ok;
	logic signed [DATA_W-1:0] rd_val, res_dout;
	logic signed [DATA_W-1:0] vals [CAPACITY];
	cell_act_t                acts [CAPACITY];

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	assign pos_ext = CMPW'(position);
	assign cnt_ext = CMPW'(cnt_q);
	assign idx     = pos_ext - CMPW'(1);
	assign pos_nz  = (position != '0);
	assign in_list = pos_nz && (pos_ext <= cnt_ext);

	assign rd_ok  = acc && (opcode == OP_READ) && in_list;
	assign wr_ok  = acc && (opcode == OP_WRITE) && in_list;
	assign rem_ok = acc && (opcode == OP_REMOVE) && in_list;
	assign ins_ok = acc && (opcode == OP_INSERT) && pos_nz &&
		(pos_ext <= cnt_ext + CMPW'(1)) && (cnt_ext < CMPW'(CAPACITY));
	assign clr    = acc && (opcode == OP_CLEAR);
	assign res_ok = rd_ok || wr_ok || rem_ok || ins_ok || clr;

	assign rd_val   = vals[idx[IW-1:0]];
	assign res_dout = (rd_ok || rem_ok) ? rd_val : '0;

	always_comb begin
		cnt_nxt = cnt_ext;
		if (clr)
			cnt_nxt = '0;
		else if (ins_ok)
			cnt_nxt = cnt_ext + CMPW'(1);
		else if (rem_ok)
			cnt_nxt = cnt_ext - CMPW'(1);
	end

	// per-cell: insert pulls from the left, remove from the right, write loads
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [DATA_W-1:0] left_v, right_v;

		always_comb begin
			acts[k] = ACT_HOLD;
			if (ins_ok) begin
				if (CMPW'(k) > idx)
					acts[k] = ACT_LEFT;
				else if (CMPW'(k) == idx)
					acts[k] = ACT_LOAD;
			end else if (wr_ok && (CMPW'(k) == idx)) begin
				acts[k] = ACT_LOAD;
			end else if (rem_ok && (CMPW'(k) >= idx)) begin
				acts[k] = ACT_RIGHT;
			end
		end

		if (k == 0) begin : g_first
			assign left_v = data_in;
		end else begin : g_mid_l
			assign left_v = vals[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_v = vals[k];
		end else begin : g_mid_r
			assign right_v = vals[k+1];
		end

		pol_cell u_cell (
			.clk       (clk),
			.act       (acts[k]),
			.din       (data_in),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (vals[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc)
				cnt_q <= cnt_nxt[CW-1:0];
			if (acc)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q    <= res_ok;
			dout_q  <= res_dout;
			count_q <= cnt_nxt[COUNT_W-1:0];
			empty_q <= (cnt_nxt == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign data_out  = dout_q;
	assign count     = count_q;
	assign empty_res = empty_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(cnt_q) <= CMPW'(CAPACITY))
		else $error("entry count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> dout_q == '0)
		else $error("rejected item returned data");

	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> empty_q == (cnt_q == '0))
		else $error("empty flag disagrees with entry count");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the list");

endmodule
